// ===== src/mpq_pkg.sv =====
// Shared types and constants for the max priority queue.
// Used by mpq_ctrl, mpq_dpath and max_priority_queue; depends on nothing.
package mpq_pkg;

    // Queue depth and the widths that follow from it.
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    // Operation codes of a request.
    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } mpq_op_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } mpq_status_t;

    // Request payload.
    typedef struct packed {
        mpq_op_t                   op;
        logic signed [DATA_W-1:0]  value;
    } mpq_req_t;

    // Response payload.
    typedef struct packed {
        mpq_status_t               status;
        logic signed [DATA_W-1:0]  removed_value;
        logic [CNT_W-1:0]          held_count;
    } mpq_rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic push;
        logic flag_full;
        logic flag_empty;
        logic scan_start;
        logic scan_step;
        logic remove;
        logic emit;
    } mpq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_deq;
        logic is_full;
        logic is_empty;
        logic scan_last;
        logic out_free;
    } mpq_stat_t;

endpackage

// ===== src/mpq_dpath.sv =====
// Datapath of the max priority queue: entry memory, fill count, maximum
// scan, result and output registers. Depends on mpq_pkg.
module mpq_dpath
    import mpq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  mpq_req_t  req,
    input  logic      rsp_stall,
    input  mpq_cmd_t  cmd,
    output mpq_stat_t stat,
    output logic      rsp_valid,
    output mpq_rsp_t  rsp
);

    // Entry storage; only entries below the fill count are ever read.
    logic signed [DATA_W-1:0] mem [CAPACITY];

    mpq_op_t                  op_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic [CNT_W-1:0]         fill_reg;
    logic [IDX_W-1:0]         scan_idx_reg;
    logic signed [DATA_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]         rd_idx_reg;
    logic                     rd_valid_reg;
    logic signed [DATA_W-1:0] best_reg;
    logic [IDX_W-1:0]         best_idx_reg;
    logic signed [DATA_W-1:0] last_reg;
    mpq_status_t              res_status_reg;
    logic signed [DATA_W-1:0] res_removed_reg;
    logic                     out_valid_reg;
    mpq_rsp_t                 out_reg;
    logic [CNT_W-1:0]         fill_last;
    logic                     take_new;

    // Status toward the controller.
    assign fill_last      = fill_reg - CNT_W'(1);
    assign stat.op_deq    = (op_reg == OP_DEQ);
    assign stat.is_full   = (fill_reg >= CNT_W'(CAPACITY));
    assign stat.is_empty  = (fill_reg == '0);
    assign stat.scan_last = ({1'b0, scan_idx_reg} == fill_last);
    assign stat.out_free  = !out_valid_reg || !rsp_stall;

    // A new maximum candidate arrives from the memory read.
    assign take_new = rd_valid_reg && ((rd_idx_reg == '0) || (best_reg < rd_data_reg));

    // Memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[fill_reg[IDX_W-1:0]] <= value_reg;
        end
        if (cmd.remove)
        begin
            mem[best_idx_reg] <= last_reg;
        end
        if (cmd.scan_step)
        begin
            rd_data_reg <= mem[scan_idx_reg];
        end
    end

    // Control state: fill count, read pipeline valid, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.scan_step;
            if (cmd.push)
            begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
            else if (cmd.remove)
            begin
                fill_reg <= fill_last;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: request, scan, result and output.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= req.op;
            value_reg <= req.value;
        end
        if (cmd.scan_start)
        begin
            scan_idx_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
        end
        if (cmd.scan_step)
        begin
            rd_idx_reg <= scan_idx_reg;
        end
        if (take_new)
        begin
            best_reg     <= rd_data_reg;
            best_idx_reg <= rd_idx_reg;
        end
        // The scan ends on the last held entry, so this keeps its value.
        if (rd_valid_reg)
        begin
            last_reg <= rd_data_reg;
        end
        if (cmd.push)
        begin
            res_status_reg  <= ST_DONE;
            res_removed_reg <= '0;
        end
        else if (cmd.flag_full)
        begin
            res_status_reg  <= ST_FULL;
            res_removed_reg <= '0;
        end
        else if (cmd.flag_empty)
        begin
            res_status_reg  <= ST_EMPTY;
            res_removed_reg <= '0;
        end
        else if (cmd.remove)
        begin
            res_status_reg  <= ST_DONE;
            res_removed_reg <= best_reg;
        end
        if (cmd.emit)
        begin
            out_reg.status        <= res_status_reg;
            out_reg.removed_value <= res_removed_reg;
            out_reg.held_count    <= fill_reg;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

`ifndef ASSERT_OFF
    // The fill count never exceeds the capacity.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    // A push is never issued on a full queue.
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (fill_reg < CNT_W'(CAPACITY)))
        else $error("push on full queue");

    // A removal drops the fill count by exactly one.
    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.remove |=> (fill_reg == CNT_W'($past(fill_reg) - CNT_W'(1))))
        else $error("removal did not decrement fill count");

    // Scan reads stay below the fill count.
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> ({1'b0, rd_idx_reg} < fill_reg))
        else $error("scan read beyond held entries");

    // A new result never overwrites one that is still stalled.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || !rsp_stall))
        else $error("result overwritten while stalled");
`endif

endmodule

// ===== src/mpq_ctrl.sv =====
// Controller of the max priority queue: sequences accept, decision, maximum
// scan, removal and result transfer. Depends on mpq_pkg.
module mpq_ctrl
    import mpq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  mpq_stat_t stat,
    output mpq_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_DRAIN,
        S_REMOVE,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // One request at a time is taken, only while idle.
    assign req_stall = (state_reg != S_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!stat.op_deq)
                begin
                    cmd.push      = !stat.is_full;
                    cmd.flag_full = stat.is_full;
                    state_next    = S_RESULT;
                end
                else if (stat.is_empty)
                begin
                    cmd.flag_empty = 1'b1;
                    state_next     = S_RESULT;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_REMOVE;
            end
            S_REMOVE:
            begin
                cmd.remove = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/max_priority_queue.sv =====
// Top level of the max priority queue: controller plus datapath.
// Depends on mpq_pkg, mpq_ctrl and mpq_dpath.
//
// Usage: a request transfer (req_valid high, req_stall low) carries an op
// and a value. An enqueue stores the value, or reports full and drops it
// when CAPACITY entries are held. A dequeue removes the largest held value
// and returns it, or reports empty. Every request gives exactly one
// response transfer on rsp with status, removed value and held count.
// An enqueue or a refused dequeue goes from the decision straight to the
// result; a dequeue first scans the held entries, drains the read
// register and removes the maximum. The dequeue time is set by the maximum
// scan, which reads one entry per cycle through the single read port of
// the entry memory. One request is in work at a time; req_stall is low
// only while the block is idle, which it reaches in the cycle after the
// result is loaded, so a request is taken only once the last is through.
// Reset clears the held count and the output valid; entry contents are
// not cleared and need no clearing pass. The response sits in an output
// register: a stalled receiver holds it stable, and the block still takes
// the next request, waiting with its result until the register frees.
module max_priority_queue
    import mpq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  mpq_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output mpq_rsp_t rsp
);

    mpq_cmd_t  cmd;
    mpq_stat_t stat;

    // Sequencer.
    mpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Storage, scan and output registers.
    mpq_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule
